[hw/rtl/ckl_pkg.sv]
// Shared types and constants for the codeword unpack and key lookup block.
// No dependencies; ckl_unpack, ckl_out_buf, the top level and the testbench import it.
package ckl_pkg;

	// Bit accumulator: leftover bits plus one freshly appended byte.
	localparam int ACC_W  = 32;
	localparam int WORK_W = ACC_W + 8;

	// Input item kinds.
	localparam logic KIND_KEY    = 1'b0;
	localparam logic KIND_CIPHER = 1'b1;

	// Configuration register indexes.
	localparam logic REG_CODE_WIDTH = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	// Configuration reset values.
	localparam logic [4:0]  CODE_WIDTH_RST = 5'd17;
	localparam logic [16:0] KEY_LENGTH_RST = 17'd65536;

	// Plain byte returned for a position outside the key.
	localparam logic [7:0] UNDERSCORE = 8'd95;

	// Control that accompanies one key store read.
	typedef struct packed {
		logic valid;
		logic oor;
		logic last;
	} rd_ctl_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0] plain_byte;
		logic       out_of_range;
		logic       last;
	} result_t;

endpackage

[hw/rtl/ckl_key_mem.sv]
// Key store: synchronous RAM with one write port and one registered read port.
// Depends on nothing but its parameters.
module ckl_key_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] key_ram_q [DEPTH];
	logic [7:0] rdata_q;

	// Write and read; read data is registered and appears in the cycle after the address.
	always_ff @(posedge clk) begin
		if (we) begin
			key_ram_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= key_ram_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ckl_unpack.sv]
// Bit accumulator and codeword sequencer: appends cipher bytes and issues one
// key store read per complete codeword. Depends on ckl_pkg.
module ckl_unpack import ckl_pkg::*; #(
	parameter int KEY_DEPTH      = 65536,
	parameter int MAX_CODE_WIDTH = 24,
	parameter int AW             = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept_cipher,
	input  logic [7:0]    data_byte,
	input  logic          end_of_message,
	input  logic [4:0]    code_width,
	input  logic [16:0]   key_length,
	input  logic          issue_ok,
	output logic          busy,
	output logic [AW-1:0] rd_addr,
	output rd_ctl_t       rd_ctl
);

	localparam int PW = MAX_CODE_WIDTH;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t            state_q;
	logic [WORK_W-1:0] work_q;
	logic [5:0]        cnt_q;
	logic [2:0]        n_q;
	logic              eom_q;

	logic [5:0]        w_eff;
	logic [31:0]       lim;
	logic              can_emit;
	logic              issue;
	logic [5:0]        new_cnt;
	logic [5:0]        keep_cnt;
	logic [WORK_W-1:0] shifted;
	logic [PW-1:0]     pos;
	logic [31:0]       pos_ext;
	logic              last_cw;
	logic              finish;
	logic [WORK_W-1:0] leftover;

	// Effective codeword width and key length.
	always_comb begin
		if (code_width == 5'd0) begin
			w_eff = 6'd1;
		end else if (6'(code_width) > 6'(MAX_CODE_WIDTH)) begin
			w_eff = 6'(MAX_CODE_WIDTH);
		end else begin
			w_eff = 6'(code_width);
		end
		if (32'(key_length) > 32'(KEY_DEPTH)) begin
			lim = 32'(KEY_DEPTH);
		end else begin
			lim = 32'(key_length);
		end
	end

	// Extract the oldest complete codeword.
	always_comb begin
		can_emit = (state_q == ST_RUN) && (cnt_q >= w_eff);
		issue    = can_emit && issue_ok;
		new_cnt  = cnt_q - w_eff;
		shifted  = work_q >> new_cnt;
		pos      = shifted[PW-1:0] & ~({PW{1'b1}} << w_eff);
		pos_ext  = 32'(pos);
		last_cw  = (new_cnt < w_eff) || (n_q == 3'd7);
		finish   = (state_q == ST_RUN) && (!can_emit || (issue && last_cw));
		keep_cnt = can_emit ? new_cnt : cnt_q;
		leftover = work_q & ~({WORK_W{1'b1}} << keep_cnt);
	end

	assign rd_addr      = pos_ext[AW-1:0];
	assign rd_ctl.valid = issue;
	assign rd_ctl.oor   = pos_ext >= lim;
	assign rd_ctl.last  = last_cw;
	assign busy         = (state_q == ST_RUN);

	// Sequencer state and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			work_q  <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			eom_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept_cipher) begin
						work_q  <= {work_q[ACC_W-1:0], data_byte};
						cnt_q   <= cnt_q + 6'd8;
						n_q     <= '0;
						eom_q   <= end_of_message;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (eom_q || keep_cnt == 6'd0) begin
							work_q <= '0;
							cnt_q  <= '0;
						end else begin
							work_q <= leftover;
							cnt_q  <= keep_cnt;
						end
					end else if (issue) begin
						cnt_q <= new_cnt;
						n_q   <= n_q + 3'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/ckl_out_buf.sv]
// Two-entry result buffer that decouples key store reads from the output
// stall. Depends on ckl_pkg.
module ckl_out_buf import ckl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  result_t    push_data,
	input  logic       pop,
	output logic       not_empty,
	output logic [1:0] level,
	output result_t    head
);

	result_t    buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			level_q <= level_q + 2'(push) - 2'(pop);
		end
	end

	assign not_empty = (level_q != 2'd0);
	assign level     = level_q;
	assign head      = buf_q[rd_ptr_q];

endmodule

[hw/rtl/codeword_unpack_key_lookup.sv]
// Book-cipher decoder: key loads never stall the input. A cipher byte is accepted and then
// stalls the input while its complete codewords (0 to 8) are looked up one at a time
// through the single key store read port, each only while the result buffer has room.
// Each result is registered at the read port and again in the result buffer.
// Reset (asynchronous, active low) clears the accumulator, sequencer, buffer
// and configuration (code_width 17, key_length 65536); the key store is not cleared.
module codeword_unpack_key_lookup import ckl_pkg::*; #(
	parameter int KEY_DEPTH      = 65536,
	parameter int MAX_CODE_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] key_address,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  plain_byte,
	output logic        out_of_range,
	output logic        last
);

	localparam int AW = $clog2(KEY_DEPTH);

	logic [4:0]    code_width_q;
	logic [16:0]   key_length_q;
	logic          accept;
	logic          busy;
	logic          key_we;
	logic [31:0]   key_addr_ext;
	logic [AW-1:0] rd_addr;
	rd_ctl_t       rd_ctl;
	rd_ctl_t       ctl_s1;
	logic [7:0]    rdata;
	logic          pop;
	logic [1:0]    level;
	logic [2:0]    occ;
	logic          issue_ok;
	result_t       push_data;
	result_t       head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_width_q <= CODE_WIDTH_RST;
			key_length_q <= KEY_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODE_WIDTH: code_width_q <= cfg_data[4:0];
				REG_KEY_LENGTH: key_length_q <= cfg_data;
				default:        code_width_q <= code_width_q;
			endcase
		end
	end

	// Input transaction; the store is never read while a load can be taken.
	assign in_stall     = busy;
	assign accept       = in_valid && !in_stall;
	assign key_addr_ext = 32'(key_address);
	assign key_we       = accept && (kind == KIND_KEY) && (key_addr_ext < 32'(KEY_DEPTH));

	ckl_unpack #(
		.KEY_DEPTH      (KEY_DEPTH),
		.MAX_CODE_WIDTH (MAX_CODE_WIDTH),
		.AW             (AW)
	) u_unpack (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept_cipher  (accept && (kind == KIND_CIPHER)),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.code_width     (code_width_q),
		.key_length     (key_length_q),
		.issue_ok       (issue_ok),
		.busy           (busy),
		.rd_addr        (rd_addr),
		.rd_ctl         (rd_ctl)
	);

	ckl_key_mem #(
		.DEPTH (KEY_DEPTH),
		.AW    (AW)
	) u_key_mem (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_addr_ext[AW-1:0]),
		.wdata (data_byte),
		.re    (rd_ctl.valid),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Read control follows the read data by one stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= rd_ctl;
		end
	end

	// A read is issued only when the buffer will have room for its data.
	assign pop      = out_valid && !out_stall;
	assign occ      = 3'(level) + 3'(ctl_s1.valid);
	assign issue_ok = (occ < 3'd2) || ((occ == 3'd2) && pop);

	assign push_data.plain_byte   = ctl_s1.oor ? UNDERSCORE : rdata;
	assign push_data.out_of_range = ctl_s1.oor;
	assign push_data.last         = ctl_s1.last;

	ckl_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctl_s1.valid),
		.push_data (push_data),
		.pop       (pop),
		.not_empty (out_valid),
		.level     (level),
		.head      (head)
	);

	assign plain_byte   = head.plain_byte;
	assign out_of_range = head.out_of_range;
	assign last         = head.last;

endmodule

[hw/rtl/ckl_checker.sv]
// Port-level checks for the codeword unpack and key lookup block, bound to
// the top level. Depends only on the top level's port names.
module ckl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       kind,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] plain_byte,
	input logic       out_of_range,
	input logic       last
);

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(plain_byte)
			&& $stable(out_of_range) && $stable(last))
		else $error("result changed while stalled");

	// A key load never holds off the next transaction.
	a_key_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !kind |=> !in_stall)
		else $error("stall after a key load");

	// An accepted cipher byte stalls the input in the cycle after it.
	a_cipher_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind |=> in_stall)
		else $error("no stall after a cipher byte");

	// An out-of-range result always carries an underscore.
	a_oor_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> plain_byte == 8'd95)
		else $error("out-of-range result without underscore");

endmodule

bind codeword_unpack_key_lookup ckl_checker u_ckl_checker (.*);

[test/tb_codeword_unpack_key_lookup.sv]
// Self-checking testbench for codeword_unpack_key_lookup: directed rows, then random messages.
// Depends on ckl_pkg and the codeword_unpack_key_lookup RTL only.
// Expected plain bytes come from a behavioural predictor kept alongside the stimulus.
module tb_codeword_unpack_key_lookup;
	import ckl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_SIZE      = 65536;
	localparam int MAX_CODE_BITS = 24;
	localparam int ITEM_GOAL     = 410;
	localparam int CALM_FROM     = 350;

	typedef enum {ROW_REG, ROW_KEY, ROW_CIPHER} row_act_t;
	typedef enum {EXP_MODEL, EXP_NONE, EXP_ONE} row_exp_t;

	typedef struct {
		row_act_t    act;
		logic        idx;
		logic [16:0] value;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        eom;
		row_exp_t    how;
		logic [7:0]  want_byte;
		logic        want_oor;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [16:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_KEY;
	logic [15:0] key_address = '0;
	logic [7:0]  data_byte = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  plain_byte;
	logic        out_of_range;
	logic        last;

	// Predictor state: configuration, bit accumulator and a shadow of the key store.
	logic [4:0]  cw_reg = CODE_WIDTH_RST;
	logic [16:0] kl_reg = KEY_LENGTH_RST;
	logic [31:0] acc_bits = '0;
	int unsigned acc_count = 0;
	logic [7:0]  key_mem [KEY_SIZE];
	bit          key_known [KEY_SIZE];
	int unsigned pos_list [8];
	int          pos_n;

	result_t     pending_plain [$];
	plan_row_t   plan [$];
	int          errors = 0;
	int          item_count = 0;
	int          stall_left = 0;
	logic        calm = 1'b0;

	codeword_unpack_key_lookup u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.key_address(key_address),
		.data_byte(data_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.plain_byte(plain_byte),
		.out_of_range(out_of_range),
		.last(last)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// Effective codeword width and key length after clamping.
	function automatic int unsigned code_bits();
		if (cw_reg == 5'd0)
			return 1;
		if (cw_reg > MAX_CODE_BITS)
			return MAX_CODE_BITS;
		return cw_reg;
	endfunction

	function automatic int unsigned key_span();
		if (kl_reg > KEY_SIZE)
			return KEY_SIZE;
		return kl_reg;
	endfunction

	// Appends one byte to the accumulator and lists the complete codewords, oldest first.
	// The accumulator is only updated when commit is set.
	task automatic split_codewords(input logic [7:0] b, input logic eom, input bit commit);
		int unsigned w;
		int unsigned cnt;
		logic [63:0] acc_w;
		logic [63:0] msk;
		w = code_bits();
		msk = (64'd1 << w) - 64'd1;
		cnt = acc_count + 8;
		acc_w = {24'd0, acc_bits, b};
		pos_n = 0;
		while (cnt >= w && pos_n < 8) begin
			cnt -= w;
			pos_list[pos_n] = int'((acc_w >> cnt) & msk);
			pos_n++;
		end
		if (commit) begin
			if (eom || cnt == 0) begin
				acc_bits = '0;
				acc_count = 0;
			end else begin
				acc_bits = 32'(acc_w & ((64'd1 << cnt) - 64'd1));
				acc_count = cnt;
			end
		end
	endtask

	// Presents one transaction and holds it until the block takes it.
	task automatic drive_item(input logic k, input logic [15:0] a, input logic [7:0] d,
			input logic e);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		key_address <= a;
		data_byte <= d;
		end_of_message <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		item_count++;
	endtask

	task automatic send_key(input logic [15:0] a, input logic [7:0] d, input logic e);
		key_mem[a] = d;
		key_known[a] = 1'b1;
		drive_item(KIND_KEY, a, d, e);
	endtask

	// Any in-range key entry that the byte would read is loaded first, so that no
	// unwritten entry is ever looked up.
	task automatic send_cipher(input logic [7:0] b, input logic eom, input row_exp_t how,
			input logic [7:0] want_byte, input logic want_oor);
		int unsigned lim;
		result_t r;
		lim = key_span();
		split_codewords(b, eom, 1'b0);
		for (int i = 0; i < pos_n; i++)
			if (pos_list[i] < lim && !key_known[pos_list[i]])
				send_key(16'(pos_list[i]), 8'($urandom), 1'b0);
		split_codewords(b, eom, 1'b1);
		if (how == EXP_MODEL) begin
			for (int i = 0; i < pos_n; i++) begin
				if (pos_list[i] < lim) begin
					r.plain_byte = key_mem[pos_list[i]];
					r.out_of_range = 1'b0;
				end else begin
					r.plain_byte = UNDERSCORE;
					r.out_of_range = 1'b1;
				end
				r.last = (i == pos_n - 1);
				pending_plain.push_back(r);
			end
		end else if (how == EXP_ONE) begin
			r.plain_byte = want_byte;
			r.out_of_range = want_oor;
			r.last = 1'b1;
			pending_plain.push_back(r);
		end
		drive_item(KIND_CIPHER, 16'($urandom), b, eom);
	endtask

	// Stops sending and waits for every outstanding result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_plain.size() != 0)
			@(posedge clk);
	endtask

	// Register writes happen only with the block idle, after every outstanding result has drained.
	task automatic write_reg(input logic idx, input logic [16:0] val);
		drain();
		repeat (16) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CODE_WIDTH)
			cw_reg = val[4:0];
		else
			kl_reg = val;
	endtask

	task automatic add_row(input row_act_t act, input logic idx, input logic [16:0] value,
			input logic [15:0] addr, input logic [7:0] data, input logic eom,
			input row_exp_t how, input logic [7:0] want_byte, input logic want_oor);
		plan_row_t p;
		p.act = act;
		p.idx = idx;
		p.value = value;
		p.addr = addr;
		p.data = data;
		p.eom = eom;
		p.how = how;
		p.want_byte = want_byte;
		p.want_oor = want_oor;
		plan.push_back(p);
	endtask

	// Output stall: random bursts, none once the run has calmed down.
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker: each accepted transaction against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_plain.size() == 0) begin
				report_mismatch($sformatf("unexpected result plain_byte %h", plain_byte));
			end else begin
				want = pending_plain.pop_front();
				if (plain_byte !== want.plain_byte)
					report_mismatch($sformatf("plain_byte got %h want %h",
						plain_byte, want.plain_byte));
				if (out_of_range !== want.out_of_range)
					report_mismatch($sformatf("out_of_range got %b want %b",
						out_of_range, want.out_of_range));
				if (last !== want.last)
					report_mismatch($sformatf("last got %b want %b", last, want.last));
			end
		end
	end

	// Stimulus.
	initial begin
		int guard;
		int phase_len;
		int msg_len;
		logic [4:0] w5;
		logic [16:0] kl;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. Key loads at both ends of the store; end_of_message on a load is ignored.
		add_row(ROW_KEY, 0, 0, 16'd0, 8'h41, 1'b1, EXP_NONE, 0, 0);
		add_row(ROW_KEY, 0, 0, 16'hffff, 8'hff, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_KEY, 0, 0, 16'd1, 8'h00, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_KEY, 0, 0, 16'd255, 8'h5a, 1'b0, EXP_NONE, 0, 0);
		// Reset width of 17: three bytes give position 1, then a short tail is dropped.
		add_row(ROW_CIPHER, 0, 0, 0, 8'h00, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h00, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h80, 1'b0, EXP_ONE, 8'h00, 1'b0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h3c, 1'b1, EXP_NONE, 0, 0);
		// Byte-wide codewords read the key directly.
		add_row(ROW_REG, REG_CODE_WIDTH, 17'd8, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h00, 1'b0, EXP_ONE, 8'h41, 1'b0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h01, 1'b0, EXP_ONE, 8'h00, 1'b0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'hff, 1'b0, EXP_ONE, 8'h5a, 1'b0);
		// An empty key puts every position out of range.
		add_row(ROW_REG, REG_KEY_LENGTH, 17'd0, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h00, 1'b0, EXP_ONE, UNDERSCORE, 1'b1);
		// Width zero behaves as one bit: eight results per byte.
		add_row(ROW_REG, REG_CODE_WIDTH, 17'd0, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_REG, REG_KEY_LENGTH, 17'd1, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'ha5, 1'b0, EXP_MODEL, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h5a, 1'b1, EXP_MODEL, 0, 0);
		// Oversized width and length clamp to 24 bits and the full store.
		add_row(ROW_REG, REG_CODE_WIDTH, 17'h1ffff, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_REG, REG_KEY_LENGTH, 17'h1ffff, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h00, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'hff, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'hff, 1'b0, EXP_ONE, 8'hff, 1'b0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'hff, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'hff, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'hff, 1'b0, EXP_ONE, UNDERSCORE, 1'b1);
		// Nine-bit codewords, ending with a message whose tail is discarded.
		add_row(ROW_REG, REG_CODE_WIDTH, 17'd9, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_REG, REG_KEY_LENGTH, 17'h10000, 0, 0, 0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h00, 1'b0, EXP_NONE, 0, 0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'h80, 1'b0, EXP_ONE, 8'h00, 1'b0);
		add_row(ROW_CIPHER, 0, 0, 0, 8'hc3, 1'b1, EXP_MODEL, 0, 0);

		foreach (plan[i]) begin
			case (plan[i].act)
				ROW_REG: begin
					write_reg(plan[i].idx, plan[i].value);
				end
				ROW_KEY: begin
					send_key(plan[i].addr, plan[i].data, plan[i].eom);
				end
				default: begin
					send_cipher(plan[i].data, plan[i].eom, plan[i].how,
						plan[i].want_byte, plan[i].want_oor);
				end
			endcase
		end

		// Random phases: fresh configuration, then messages with random content.
		while (item_count < ITEM_GOAL) begin
			case ($urandom_range(0, 9))
				0: w5 = 5'd0;
				1: w5 = 5'd1;
				2: w5 = 5'd24;
				3: w5 = 5'($urandom_range(25, 31));
				4: w5 = 5'd8;
				5, 6: w5 = 5'($urandom_range(1, 8));
				default: w5 = 5'($urandom_range(1, 24));
			endcase
			case ($urandom_range(0, 9))
				0: kl = 17'd0;
				1: kl = 17'd1;
				2: kl = 17'd65535;
				3: kl = 17'd65536;
				4: kl = 17'($urandom_range(65537, 131071));
				5, 6: kl = 17'($urandom_range(1, 512));
				default: kl = 17'($urandom_range(0, 65536));
			endcase
			write_reg(REG_CODE_WIDTH, {12'($urandom), w5});
			write_reg(REG_KEY_LENGTH, kl);
			phase_len = $urandom_range(20, 60);
			for (int j = 0; j < phase_len && item_count < ITEM_GOAL; j++) begin
				if (item_count >= CALM_FROM)
					calm <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					drain();
				if ($urandom_range(0, 7) == 0) begin
					send_key(16'($urandom), 8'($urandom), 1'($urandom));
				end else begin
					msg_len = $urandom_range(1, 12);
					for (int k = 0; k < msg_len; k++)
						send_cipher(8'($urandom), k == msg_len - 1, EXP_MODEL, 0, 0);
					j += msg_len - 1;
				end
			end
		end

		// Let the last results drain, then allow for the block's own latency.
		in_valid <= 1'b0;
		for (guard = 0; guard < 20000 && pending_plain.size() != 0; guard++)
			@(posedge clk);
		if (pending_plain.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_plain.size()));
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
